// ===== design/kcc_pkg.sv =====
`default_nettype none

package kcc_pkg;

    // Number of keys handled side by side; the poll fields carry FIELD_W of them.
    localparam int KEYS      = 4;
    localparam int FIELD_W   = 4;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = CFG_W'(400);
    localparam logic [CFG_W-1:0] LONG_PRESS_RST    = CFG_W'(800);

    // What one key lane reports for the current poll.
    typedef struct packed {
        logic single_click;
        logic double_click;
        logic long_press;
    } t_hit;

    typedef struct packed {
        logic [FIELD_W-1:0] single_clicks;
        logic [FIELD_W-1:0] double_clicks;
        logic [FIELD_W-1:0] long_presses;
    } t_res;

endpackage

`default_nettype wire

// ===== design/kcc_in_if.sv =====
`default_nettype none

interface kcc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [kcc_pkg::TIME_W-1:0]           now_ms;
    logic [kcc_pkg::FIELD_W-1:0]          press_edges;
    logic [kcc_pkg::FIELD_W-1:0]          released_levels;

    modport source (output valid, now_ms, press_edges, released_levels, input ready);
    modport sink   (input valid, now_ms, press_edges, released_levels, output ready);
endinterface

`default_nettype wire

// ===== design/kcc_res_if.sv =====
`default_nettype none

interface kcc_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [kcc_pkg::FIELD_W-1:0]          single_clicks;
    logic [kcc_pkg::FIELD_W-1:0]          double_clicks;
    logic [kcc_pkg::FIELD_W-1:0]          long_presses;

    modport source (output valid, single_clicks, double_clicks, long_presses, input ready);
    modport sink   (input valid, single_clicks, double_clicks, long_presses, output ready);
endinterface

`default_nettype wire

// ===== design/kcc_cfg_if.sv =====
`default_nettype none

interface kcc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [kcc_pkg::CFG_IDX_W-1:0]        index;
    logic [kcc_pkg::CFG_W-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/key_click_classifier.sv =====
// Key click classifier: each poll transfer carries a millisecond timestamp plus, for four
// keys, a press-edge bit and a released-level bit; the matching result transfer carries one
// bit per key for single click, double click and long press. One poll is taken every clock
// cycle while ready is high (ready drops while the skid entry is full) and its result is
// registered; each per-key lane updates its phase and timestamps from a 32-bit wrapping
// subtract and a compare against the 16-bit limit. A two-entry output (result register
// plus skid entry) keeps the poll side open while one result waits to be taken. A double
// click needs the second press strictly inside the window after release; a single click is
// reported once the gap strictly exceeds the window; a long press needs a hold strictly
// longer than the long-press limit. Register 0 is the double-click window (reset 400 ms),
// register 1 the long-press limit (reset 800 ms); other indexes are ignored. Write them
// only while no poll is in flight.
`default_nettype none

module key_click_classifier (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    kcc_in_if.sink        i_in,
    kcc_cfg_if.sink       i_cfg,
    kcc_res_if.source     o_res
);
    import kcc_pkg::*;

    // configuration registers
    logic [CFG_W-1:0]   r_window;
    logic [CFG_W-1:0]   r_long;

    logic               w_accept;
    logic               w_ready;
    t_hit [KEYS-1:0]    w_hits;

    // Writes always complete; unknown indexes drop the data.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= DOUBLE_WINDOW_RST;
            r_long   <= LONG_PRESS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DOUBLE_WINDOW: r_window <= i_cfg.data;
                REG_LONG_PRESS:    r_long   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A poll transfer moves every lane one step at the same edge.
    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    // One lane per key; keys beyond the poll fields see no edge and read pressed.
    for (genvar k = 0; k < KEYS; k++) begin : g_lane
        logic w_edge, w_released;
        if (k < FIELD_W) begin : g_in
            assign w_edge     = i_in.press_edges[k];
            assign w_released = i_in.released_levels[k];
        end else begin : g_none
            assign w_edge     = 1'b0;
            assign w_released = 1'b0;
        end

        kcc_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_accept),
            .i_now_ms   (i_in.now_ms),
            .i_edge     (w_edge),
            .i_released (w_released),
            .i_window   (r_window),
            .i_long     (r_long),
            .o_hit      (w_hits[k])
        );
    end

    // Merge lane hits into the result and hold it for the sink.
    kcc_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_hits   (w_hits),
        .o_ready  (w_ready),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// ===== design/kcc_lane.sv =====
`default_nettype none

// One key: phase machine plus its press and release timestamps.
module kcc_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [kcc_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic                         i_edge,
    input  wire logic                         i_released,
    input  wire logic [kcc_pkg::CFG_W-1:0]    i_window,
    input  wire logic [kcc_pkg::CFG_W-1:0]    i_long,
    output kcc_pkg::t_hit                     o_hit
);
    import kcc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRESSED,
        PH_WAIT,
        PH_LONG
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [TIME_W-1:0]   r_press_time, n_press_time;
    logic [TIME_W-1:0]   r_release_time, n_release_time;
    logic                r_suppress, n_suppress;
    logic [TIME_W-1:0]   w_gap_press, w_gap_release;
    logic                w_hold_over, w_gap_over, w_gap_under;

    // Wrapping elapsed times; upper half non-zero means beyond any 16-bit limit.
    assign w_gap_press   = i_now_ms - r_press_time;
    assign w_gap_release = i_now_ms - r_release_time;
    assign w_hold_over   = (w_gap_press[TIME_W-1:CFG_W] != '0)
                         || (w_gap_press[CFG_W-1:0] > i_long);
    assign w_gap_over    = (w_gap_release[TIME_W-1:CFG_W] != '0)
                         || (w_gap_release[CFG_W-1:0] > i_window);
    assign w_gap_under   = (w_gap_release[TIME_W-1:CFG_W] == '0)
                         && (w_gap_release[CFG_W-1:0] < i_window);

    always_comb begin
        n_phase        = r_phase;
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        n_suppress     = r_suppress;
        o_hit          = '0;
        unique case (r_phase)
            PH_IDLE: begin
                // fresh press: zero hold, so no long press and no timeout this poll
                if (i_edge) begin
                    n_press_time = i_now_ms;
                    n_suppress   = 1'b0;
                    if (i_released) begin
                        n_phase        = PH_WAIT;
                        n_release_time = i_now_ms;
                    end else begin
                        n_phase = PH_PRESSED;
                    end
                end
            end
            PH_PRESSED: begin
                if (w_hold_over) begin
                    o_hit.long_press = 1'b1;
                    n_suppress       = 1'b1;
                    n_phase          = i_released ? PH_IDLE : PH_LONG;
                end else if (i_released) begin
                    n_phase        = PH_WAIT;
                    n_release_time = i_now_ms;
                end
            end
            PH_WAIT: begin
                // gap equal to the window: neither outcome, keep waiting
                if (i_edge && w_gap_under) begin
                    o_hit.double_click = 1'b1;
                    n_suppress         = 1'b1;
                    n_phase            = PH_IDLE;
                end else if (w_gap_over) begin
                    o_hit.single_click = !r_suppress;
                    n_phase            = PH_IDLE;
                end
            end
            PH_LONG: begin
                if (i_released) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_press_time   <= '0;
            r_release_time <= '0;
            r_suppress     <= 1'b1;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
            r_suppress     <= n_suppress;
        end
    end

endmodule

`default_nettype wire

// ===== design/kcc_merge.sv =====
`default_nettype none

// Packs lane hits into the result vectors; output register plus one skid entry.
module kcc_merge (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  kcc_pkg::t_hit [kcc_pkg::KEYS-1:0]      i_hits,
    output logic                                   o_ready,
    kcc_res_if.source                              o_res
);
    import kcc_pkg::*;

    t_res   w_res;
    t_res   r_out, r_skid;
    logic   r_out_valid, r_skid_valid;
    logic   w_take;

    for (genvar j = 0; j < FIELD_W; j++) begin : g_bit
        if (j < KEYS) begin : g_key
            assign w_res.single_clicks[j] = i_hits[j].single_click;
            assign w_res.double_clicks[j] = i_hits[j].double_click;
            assign w_res.long_presses[j]  = i_hits[j].long_press;
        end else begin : g_none
            assign w_res.single_clicks[j] = 1'b0;
            assign w_res.double_clicks[j] = 1'b0;
            assign w_res.long_presses[j]  = 1'b0;
        end
    end

    assign w_take  = r_out_valid && o_res.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_accept) begin
            if (!r_out_valid || w_take) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= w_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.single_clicks = r_out.single_clicks;
    assign o_res.double_clicks = r_out.double_clicks;
    assign o_res.long_presses  = r_out.long_presses;

endmodule

`default_nettype wire

// ===== design/kcc_checker.sv =====
`default_nettype none

module kcc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [kcc_pkg::FIELD_W-1:0]     i_singles,
    input  wire logic [kcc_pkg::FIELD_W-1:0]     i_doubles,
    input  wire logic [kcc_pkg::FIELD_W-1:0]     i_longs
);

    // nothing pending straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an accepted poll shows a result on the next cycle
    a_poll_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted poll gave no result");

    // a key reports at most one kind of event per poll
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_singles & i_doubles) == '0) && ((i_singles & i_longs) == '0)
                        && ((i_doubles & i_longs) == '0))
        else $error("key reported two events in one poll");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("stalled result dropped");

endmodule

bind key_click_classifier kcc_checker u_kcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_singles   (o_res.single_clicks),
    .i_doubles   (o_res.double_clicks),
    .i_longs     (o_res.long_presses)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
    import kcc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 9;
    localparam int POLLS_PER_PHASE = 195;
    // Slack after the last owed result has come in.
    localparam int SETTLE_CYCLES   = 3;
    localparam int TAIL_CYCLES     = 8;

    // Indexes the block decodes to nothing; written now and then to show they are harmless.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRESSED,
        PH_WAIT,
        PH_LONG
    } t_key_phase;

    // Per-key click classifier mirror plus the queue of results still owed by the block.
    class click_scoreboard;
        logic [CFG_W-1:0]  window_ms;
        logic [CFG_W-1:0]  long_ms;
        t_key_phase        phase      [KEYS];
        logic [TIME_W-1:0] press_at   [KEYS];
        logic [TIME_W-1:0] release_at [KEYS];
        bit                suppress   [KEYS];
        t_res              owed[$];
        int                errors;
        int                results_seen;

        function new();
            window_ms = DOUBLE_WINDOW_RST;
            long_ms   = LONG_PRESS_RST;
            for (int k = 0; k < KEYS; k++) begin
                phase[k]      = PH_IDLE;
                press_at[k]   = '0;
                release_at[k] = '0;
                suppress[k]   = 1'b1;
            end
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DOUBLE_WINDOW: window_ms = val;
                REG_LONG_PRESS:    long_ms   = val;
                default: ;
            endcase
        endfunction

        // Advance every key by one poll and queue the clicks it should report.
        function void note_poll(logic [TIME_W-1:0] now, logic [FIELD_W-1:0] edges,
                                logic [FIELD_W-1:0] released);
            t_res              res;
            t_key_phase        ph;
            logic [TIME_W-1:0] span;
            res = '0;
            for (int k = 0; k < KEYS; k++) begin
                ph = phase[k];
                if (edges[k]) begin
                    span = now - release_at[k];
                    if (ph == PH_IDLE) begin
                        press_at[k] = now;
                        ph          = PH_PRESSED;
                        suppress[k] = 1'b0;
                    end else if (ph == PH_WAIT && span < TIME_W'(window_ms)) begin
                        res.double_clicks[k] = 1'b1;
                        ph                   = PH_IDLE;
                        suppress[k]          = 1'b1;
                    end
                end
                span = now - press_at[k];
                if (ph == PH_PRESSED && span > TIME_W'(long_ms)) begin
                    res.long_presses[k] = 1'b1;
                    ph                  = PH_LONG;
                    suppress[k]         = 1'b1;
                end
                if (released[k]) begin
                    if (ph == PH_PRESSED) begin
                        release_at[k] = now;
                        ph            = PH_WAIT;
                    end else if (ph == PH_LONG) begin
                        ph = PH_IDLE;
                    end
                end
                span = now - release_at[k];
                if (ph == PH_WAIT && span > TIME_W'(window_ms)) begin
                    if (!suppress[k])
                        res.single_clicks[k] = 1'b1;
                    ph = PH_IDLE;
                end
                phase[k] = ph;
            end
            owed.push_back(res);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(t_res got);
            t_res want;
            if (owed.size() == 0) begin
                report($sformatf("result s=%h d=%h l=%h with no poll outstanding",
                                 got.single_clicks, got.double_clicks, got.long_presses));
                return;
            end
            want = owed.pop_front();
            if (got.single_clicks !== want.single_clicks)
                report($sformatf("result %0d single_clicks %h, want %h", results_seen,
                                 got.single_clicks, want.single_clicks));
            if (got.double_clicks !== want.double_clicks)
                report($sformatf("result %0d double_clicks %h, want %h", results_seen,
                                 got.double_clicks, want.double_clicks));
            if (got.long_presses !== want.long_presses)
                report($sformatf("result %0d long_presses %h, want %h", results_seen,
                                 got.long_presses, want.long_presses));
            results_seen++;
        endtask

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   burst_left;

    kcc_in_if  in_if ();
    kcc_res_if res_if ();
    kcc_cfg_if cfg_if ();

    click_scoreboard sb;

    key_click_classifier i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result side: check every transfer, then pick the next ready level. The stall
    // mode is picked anew at random: always ready, coin toss, rare stalls,
    // or long stalls with ready only now and then.
    int unsigned stall_mode;
    int unsigned stall_mode_left;

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(t_res'{res_if.single_clicks, res_if.double_clicks,
                                   res_if.long_presses});
        if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(50, 300);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom_range(0, 1));
            2:       res_if.ready <= ($urandom_range(0, 7) != 0);
            default: res_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // One poll transfer. valid is left high while a burst lasts; between bursts
    // the sender drops valid for a random gap, or keeps it high.
    task send_poll(logic [TIME_W-1:0] now, logic [FIELD_W-1:0] edges,
                   logic [FIELD_W-1:0] released);
        int unsigned gap;
        in_if.valid           <= 1'b1;
        in_if.now_ms          <= now;
        in_if.press_edges     <= edges;
        in_if.released_levels <= released;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sb.note_poll(now, edges, released);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Hold polls back until every owed result is in, so the block is idle.
    task settle();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.set_reg(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [TIME_W-1:0]  now_t;
        logic [TIME_W-1:0]  step;
        logic [FIELD_W-1:0] edges;
        logic [FIELD_W-1:0] released;
        logic [FIELD_W-1:0] pin_down;
        logic [CFG_W-1:0]   win;
        logic [CFG_W-1:0]   lng;
        int unsigned        scale;
        int unsigned        pick;

        sb                    = new();
        rst_n                 = 1'b0;
        in_if.valid           = 1'b0;
        in_if.now_ms          = '0;
        in_if.press_edges     = '0;
        in_if.released_levels = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        res_if.ready          = 1'b0;
        stall_mode            = 0;
        stall_mode_left       = 0;
        burst_left            = 0;
        pin_down              = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed polls at the reset limits: window 400 ms, long press 800 ms.
        send_poll(32'd1000, 4'b0001, 4'b1110);  // key 0 down
        send_poll(32'd1300, 4'b0000, 4'b1111);  // key 0 up, waiting
        send_poll(32'd1700, 4'b0000, 4'b1111);  // gap equals window: still waiting
        send_poll(32'd1701, 4'b0000, 4'b1111);  // one past: single click
        send_poll(32'd2000, 4'b0001, 4'b1110);
        send_poll(32'd2100, 4'b0000, 4'b1111);
        send_poll(32'd2499, 4'b0001, 4'b1110);  // second press just inside: double
        send_poll(32'd2600, 4'b0000, 4'b1111);
        send_poll(32'd3000, 4'b0010, 4'b1101);  // key 1 held
        send_poll(32'd3800, 4'b0000, 4'b1101);  // hold equals limit: nothing yet
        send_poll(32'd3801, 4'b0000, 4'b1101);  // long press
        send_poll(32'd3900, 4'b0000, 4'b1111);  // let go after long press
        send_poll(32'd4000, 4'b0100, 4'b1011);  // key 2 down
        send_poll(32'd4801, 4'b0000, 4'b1111);  // long press and release in one poll
        send_poll(32'hFFFF_FF00, 4'b1000, 4'b0111);  // key 3 down just before wrap
        send_poll(32'hFFFF_FFFF, 4'b0000, 4'b0111);
        send_poll(32'h0000_0000, 4'b0000, 4'b0111);
        send_poll(32'h0000_0100, 4'b0000, 4'b1111);  // release across the wrap
        send_poll(32'h0000_0300, 4'b0000, 4'b1111);  // single click after wrap
        send_poll(32'd5000, 4'b1111, 4'b1111);  // all keys press and release at once
        send_poll(32'd5200, 4'b1111, 4'b1111);  // double on all four
        send_poll(32'd6000, 4'b0001, 4'b1110);
        send_poll(32'd6100, 4'b0001, 4'b1110);  // edge while already pressed: ignored
        send_poll(32'd6200, 4'b0000, 4'b1111);
        now_t = 32'd6200;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin win = 16'd0;     lng = 16'd0;     end
                1: begin win = 16'd65535; lng = 16'd65535; end
                2: begin win = 16'd0;     lng = 16'd65535; end
                3: begin win = 16'd65535; lng = 16'd0;     end
                4: begin win = 16'd1;     lng = 16'd1;     end
                default: begin
                    win = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 2000));
                    lng = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 2000));
                end
            endcase
            settle();
            write_reg(REG_DOUBLE_WINDOW, win);
            write_reg(REG_LONG_PRESS, lng);
            if ($urandom_range(0, 1) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                          16'($urandom));

            // Time steps scale with the limits so that every outcome stays in reach.
            scale = 32'((win > lng) ? win : lng);
            for (int n = 0; n < POLLS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    now_t = $urandom;
                end else if (pick < 3) begin
                    now_t = 32'hFFFF_FFFF - $urandom_range(0, scale + 100);
                end else begin
                    if (pick < 13) begin
                        case ($urandom_range(0, 4))
                            0:       step = TIME_W'(win) - 1;
                            1:       step = TIME_W'(win);
                            2:       step = TIME_W'(win) + 1;
                            3:       step = TIME_W'(lng);
                            default: step = TIME_W'(lng) + 1;
                        endcase
                    end else if (pick < 20) begin
                        step = $urandom_range(0, 2 * scale + 10);
                    end else begin
                        step = $urandom_range(0, scale / 4 + 4);
                    end
                    now_t = now_t + step;
                end

                if ($urandom_range(0, 9) == 0) begin
                    // Noise: edges and levels with no regard for the pin history.
                    edges    = 4'($urandom);
                    released = 4'($urandom);
                end else begin
                    edges = '0;
                    for (int k = 0; k < FIELD_W; k++) begin
                        if (!pin_down[k]) begin
                            if ($urandom_range(0, 5) == 0) begin
                                edges[k]    = 1'b1;
                                // a tap quicker than the poll: down and up again
                                pin_down[k] = ($urandom_range(0, 7) != 0);
                            end
                        end else if ($urandom_range(0, 3) == 0) begin
                            pin_down[k] = 1'b0;
                        end
                    end
                    released = ~pin_down;
                end
                send_poll(now_t, edges, released);

                if ($urandom_range(0, 149) == 0)
                    settle();
            end
        end

        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
